@@ rtl/ladc_pkg.sv @@
`default_nettype none

package ladc_pkg;

	localparam int unsigned EventW = 2;
	localparam int unsigned ModeW  = 2;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned DebW   = 16;
	localparam int unsigned ElapW  = 16;
	localparam int unsigned LedW   = 8;
	localparam int unsigned CfgW   = 32;
	localparam int unsigned CfgIdxW = 1;

	typedef logic [EventW-1:0] event_t;
	typedef logic [ModeW-1:0]  mode_t;
	typedef logic [TimeW-1:0]  time_t;
	typedef logic [LedW-1:0]   led_t;

	localparam event_t EV_NONE    = 2'd0;
	localparam event_t EV_FIRST   = 2'd1;
	localparam event_t EV_REPEAT  = 2'd2;
	localparam event_t EV_RECOVER = 2'd3;

	localparam mode_t MODE_NORMAL    = 2'd0;
	localparam mode_t MODE_LEAK      = 2'd1;
	localparam mode_t MODE_RECOVERED = 2'd2;

	localparam led_t LED_LEAK = 8'd255;
	localparam led_t LED_IDLE = 8'd10;

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_INTERVAL = 1'd1;

	localparam logic [DebW-1:0] DEBOUNCE_RST = 16'd100;
	localparam time_t           INTERVAL_RST = 32'd30000;

endpackage

`default_nettype wire

@@ rtl/leak_alarm_debounce_controller.sv @@
// path: input accept -> input register -> result register -> result valid
// throughput: one word per cycle while out_stall is low; the state update and all
// compares fit between input and result registers, so words wait only on out_stall
// reset: asynchronous active low; clock and times clear to 0, last level to 1,
// leak flag and mode to normal, led to 10, debounce to 100 ms, interval to 30000 ms
`default_nettype none

module leak_alarm_debounce_controller import ladc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               pin_level,
	input  wire logic [ElapW-1:0]   elapsed_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output event_t                  event_res,
	output logic                    leak_now,
	output time_t                   duration_ms,
	output led_t                    led_level,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data
);

	// configuration
	logic [DebW-1:0] debounce_q;
	time_t           interval_q;

	// input stage
	logic              valid_s1;
	logic              pin_s1;
	logic [ElapW-1:0]  elapsed_s1;

	// block state
	time_t clock_q;
	logic  prev_level_q;
	time_t change_time_q;
	logic  leak_flag_q;
	mode_t mode_q;
	time_t start_time_q;
	time_t alert_time_q;
	led_t  led_hold_q;

	// result register
	logic   out_valid_q;
	event_t event_q;
	logic   leak_q;
	time_t  duration_q;
	led_t   led_q;

	logic advance;
	logic in_take;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// next-state logic for the word in the input stage
	time_t  clock_d;
	logic   changed;
	time_t  change_time_d;
	time_t  since_change;
	logic   qualified;
	logic   leak_d;
	mode_t  mode_d;
	time_t  start_time_d;
	time_t  alert_time_d;
	led_t   led_d;
	event_t event_d;
	time_t  duration_d;
	time_t  since_alert;

	always_comb begin
		clock_d       = clock_q + {{(TimeW-ElapW){1'b0}}, elapsed_s1};
		changed       = pin_s1 != prev_level_q;
		change_time_d = changed ? clock_d : change_time_q;
		since_change  = changed ? '0 : (clock_d - change_time_q);
		if (since_change > {{(TimeW-DebW){1'b0}}, debounce_q}) begin
			qualified = !pin_s1;
		end else begin
			qualified = leak_flag_q;
		end

		leak_d       = leak_flag_q;
		mode_d       = mode_q;
		start_time_d = start_time_q;
		alert_time_d = alert_time_q;
		led_d        = led_hold_q;
		event_d      = EV_NONE;
		duration_d   = '0;

		if (qualified != leak_flag_q) begin
			leak_d = qualified;
			if (qualified) begin
				mode_d       = MODE_LEAK;
				start_time_d = clock_d;
				alert_time_d = clock_d;
				event_d      = EV_FIRST;
				led_d        = LED_LEAK;
			end else begin
				mode_d = MODE_RECOVERED;
				if (start_time_q != '0) begin
					event_d    = EV_RECOVER;
					duration_d = clock_d - start_time_q;
				end
				led_d        = LED_IDLE;
				start_time_d = '0;
			end
		end

		// repeat alert only on a word that neither starts nor ends the leak
		since_alert = clock_d - alert_time_q;
		if (event_d != EV_FIRST && leak_d && mode_d == MODE_LEAK
				&& since_alert >= interval_q) begin
			alert_time_d = clock_d;
			event_d      = EV_REPEAT;
			duration_d   = clock_d - start_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[DebW-1:0];
				REG_INTERVAL: interval_q <= cfg_data[TimeW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1     <= pin_level;
			elapsed_s1 <= elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q       <= '0;
			prev_level_q  <= 1'b1;
			change_time_q <= '0;
			leak_flag_q   <= 1'b0;
			mode_q        <= MODE_NORMAL;
			start_time_q  <= '0;
			alert_time_q  <= '0;
			led_hold_q    <= LED_IDLE;
		end else if (advance) begin
			clock_q       <= clock_d;
			prev_level_q  <= pin_s1;
			change_time_q <= change_time_d;
			leak_flag_q   <= leak_d;
			mode_q        <= mode_d;
			start_time_q  <= start_time_d;
			alert_time_q  <= alert_time_d;
			led_hold_q    <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q    <= event_d;
			leak_q     <= leak_d;
			duration_q <= duration_d;
			led_q      <= led_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = event_q;
	assign leak_now    = leak_q;
	assign duration_ms = duration_q;
	assign led_level   = led_q;

endmodule

`default_nettype wire

@@ sim/tb_leak_alarm_debounce_controller.sv @@
`default_nettype none

module tb_leak_alarm_debounce_controller;
	import ladc_pkg::*;

	localparam int unsigned QUIET_LIMIT = 1000;

	typedef struct packed {
		logic             pin;
		logic [ElapW-1:0] el;
	} sample_t;

	typedef struct packed {
		event_t ev;
		logic   leak;
		time_t  dur;
		led_t   led;
	} alarm_word_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               pin_level = 1'b1;
	logic [ElapW-1:0]   elapsed_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	event_t             event_res;
	logic               leak_now;
	time_t              duration_ms;
	led_t               led_level;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;

	leak_alarm_debounce_controller dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pin_level   (pin_level),
		.elapsed_ms  (elapsed_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.leak_now    (leak_now),
		.duration_ms (duration_ms),
		.led_level   (led_level),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// alarm state as the block should hold it
	logic [DebW-1:0] debounce_cfg = DEBOUNCE_RST;
	time_t           interval_cfg = INTERVAL_RST;
	time_t           now_ms = '0;
	logic            last_level = 1'b1;
	time_t           level_since_ms = '0;
	logic            leak_q = 1'b0;
	mode_t           mode_q = MODE_NORMAL;
	time_t           start_ms = '0;
	time_t           alert_ms = '0;
	led_t            led_q = LED_IDLE;

	sample_t     samples_to_send[$];
	alarm_word_t alarms_due[$];
	sample_t     next_sample;
	alarm_word_t want;

	bit          idle_on = 1'b1;
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned recv_wait_n;
	int unsigned quiet_cycles = 0;
	int unsigned fail_cnt = 0;
	int unsigned queued_cnt = 0;
	int unsigned sent_cnt = 0;
	int unsigned wrap_cnt = 0;
	int unsigned settings_cnt = 0;
	int unsigned ev_seen[4] = '{0, 0, 0, 0};

	task automatic advance_alarm(input logic pin, input logic [ElapW-1:0] el);
		alarm_word_t w;
		logic        qual;
		logic        carry;
		w.ev = EV_NONE;
		w.dur = '0;
		{carry, now_ms} = {1'b0, now_ms} + 33'(el);
		wrap_cnt += carry;
		if (pin != last_level) begin
			level_since_ms = now_ms;
			last_level = pin;
		end
		if (time_t'(now_ms - level_since_ms) > debounce_cfg)
			qual = ~pin;
		else
			qual = leak_q;
		if (qual != leak_q) begin
			leak_q = qual;
			if (qual) begin
				mode_q = MODE_LEAK;
				start_ms = now_ms;
				alert_ms = now_ms;
				w.ev = EV_FIRST;
				led_q = LED_LEAK;
			end else begin
				mode_q = MODE_RECOVERED;
				// a leak that began exactly at clock zero recovers silently
				if (start_ms != '0) begin
					w.ev = EV_RECOVER;
					w.dur = now_ms - start_ms;
				end
				led_q = LED_IDLE;
				start_ms = '0;
			end
		end
		if (w.ev != EV_FIRST && leak_q && mode_q == MODE_LEAK &&
				time_t'(now_ms - alert_ms) >= interval_cfg) begin
			alert_ms = now_ms;
			w.ev = EV_REPEAT;
			w.dur = now_ms - start_ms;
		end
		w.leak = leak_q;
		w.led = led_q;
		alarms_due.push_back(w);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pin_level <= 1'b1;
			elapsed_ms <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_alarm(pin_level, elapsed_ms);
				sent_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					in_valid <= 1'b0;
				end else if (samples_to_send.size() != 0) begin
					next_sample = samples_to_send.pop_front();
					pin_level <= next_sample.pin;
					elapsed_ms <= next_sample.el;
					in_valid <= 1'b1;
					send_wait <= idle_on ? $urandom_range(0, 15) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (alarms_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result word: event %0d leak %0b duration %0d led %0d",
							event_res, leak_now, duration_ms, led_level);
				end else begin
					want = alarms_due.pop_front();
					ev_seen[want.ev]++;
					if (event_res !== want.ev || leak_now !== want.leak ||
							duration_ms !== want.dur || led_level !== want.led) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$write("mismatch: expected event %0d leak %0b duration %0d led %0d,",
								want.ev, want.leak, want.dur, want.led);
							$display(" got event %0d leak %0b duration %0d led %0d",
								event_res, leak_now, duration_ms, led_level);
						end
					end
				end
				recv_wait_n = idle_on ? $urandom_range(0, 15) : 0;
			end else if (recv_wait != 0) begin
				recv_wait_n = recv_wait - 1;
			end else begin
				recv_wait_n = 0;
			end
			recv_wait <= recv_wait_n;
			out_stall <= (recv_wait_n != 0);
		end
	end

	// watchdog on words moving in either direction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_sample(input logic pin, input int unsigned el);
		sample_t s;
		s.pin = pin;
		s.el = el[ElapW-1:0];
		samples_to_send.push_back(s);
		queued_cnt++;
	endtask

	function automatic int unsigned short_elapsed();
		return $urandom_range(0, debounce_cfg / 4);
	endfunction

	function automatic int unsigned pick_elapsed();
		int unsigned v;
		case ($urandom_range(0, 9))
		0: begin
			return 0;
		end
		1: begin
			return 16'hFFFF;
		end
		2, 3: begin
			return $urandom_range(0, 16'hFFFF);
		end
		4, 5: begin
			// just under, at, or just over the debounce time
			v = debounce_cfg + $urandom_range(0, 2);
			v = (v == 0) ? 0 : v - 1;
			return (v > 16'hFFFF) ? 16'hFFFF : v;
		end
		6: begin
			return (interval_cfg <= 16'hFFFF) ? interval_cfg : $urandom_range(0, 16'hFFFF);
		end
		default: begin
			return short_elapsed();
		end
		endcase
	endfunction

	// bouncy onset, steady leak, bouncy release, steady dry
	task automatic leak_episode();
		int unsigned n;
		n = $urandom_range(0, 3);
		repeat (n) begin
			push_sample(1'b0, short_elapsed());
			push_sample(1'b1, short_elapsed());
		end
		n = $urandom_range(2, 12);
		repeat (n) push_sample(1'b0, pick_elapsed());
		n = $urandom_range(0, 2);
		repeat (n) begin
			push_sample(1'b1, short_elapsed());
			push_sample(1'b0, short_elapsed());
		end
		n = $urandom_range(2, 8);
		repeat (n) push_sample(1'b1, pick_elapsed());
	endtask

	task automatic run_random(input int unsigned n_words);
		int unsigned stop_at;
		stop_at = queued_cnt + n_words;
		while (queued_cnt < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				push_sample(1'($urandom_range(0, 1)), $urandom_range(0, 16'hFFFF));
			else
				leak_episode();
		end
	endtask

	// returns at a falling edge with nothing queued, in flight or owed
	task automatic wait_idle();
		do @(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || alarms_due.size() != 0);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEBOUNCE)
			debounce_cfg = val[DebW-1:0];
		else
			interval_cfg = val;
		@(negedge clk);
	endtask

	task automatic retune(input logic [CfgW-1:0] db, input logic [CfgW-1:0] iv);
		wait_idle();
		write_reg(REG_DEBOUNCE, db);
		write_reg(REG_INTERVAL, iv);
		settings_cnt++;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: debounce boundary, repeat alert, glitch during leak, recovery
		push_sample(1'b1, 0);
		push_sample(1'b0, 0);
		push_sample(1'b0, 100);
		push_sample(1'b0, 1);
		push_sample(1'b0, 16'hFFFF);
		push_sample(1'b1, 50);
		push_sample(1'b0, 50);
		push_sample(1'b0, 29999);
		push_sample(1'b1, 0);
		push_sample(1'b1, 101);
		push_sample(1'b1, 16'hFFFF);

		// zero debounce and zero interval: repeat on every leak word after the first
		retune(0, 0);
		push_sample(1'b0, 0);
		push_sample(1'b0, 1);
		push_sample(1'b0, 0);
		push_sample(1'b0, 7);
		push_sample(1'b1, 0);
		push_sample(1'b1, 1);

		retune(CfgW'(DEBOUNCE_RST), INTERVAL_RST);
		run_random(150);
		wait_idle();
		run_random(150);

		retune(0, 1);
		run_random(300);

		retune(16'hFFFF, 32'hFFFF_FFFF);
		run_random(300);

		// back to back in both directions
		retune(300, 70000);
		idle_on = 1'b0;
		run_random(150);

		retune($urandom_range(0, 2000), $urandom_range(1, 200000));
		run_random(250);

		retune($urandom_range(0, 500), 0);
		idle_on = 1'b1;
		run_random(300);

		wait_idle();
		repeat (10) @(posedge clk);
		if (alarms_due.size() != 0) begin
			$display("%0d expected result words never arrived", alarms_due.size());
			fail_cnt += alarms_due.size();
		end
		$display("covered %0d samples under %0d register settings, clock wrapped %0d time(s)",
			sent_cnt, settings_cnt + 1, wrap_cnt);
		$display("results: %0d quiet, %0d first alerts, %0d repeat alerts, %0d recoveries",
			ev_seen[EV_NONE], ev_seen[EV_FIRST], ev_seen[EV_REPEAT], ev_seen[EV_RECOVER]);
		if (fail_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
